>>> design/assert_macros.svh
// assertion macros shared by the scheduler rtl
// no dependencies; checks compile out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define PCS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PCS_ASSERT(label, clk, rst_n, prop, msg)
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> design/pcs_pkg.sv
// shared constants for the priority context scheduler
// field widths, operation codes and slot status codes; no dependencies
package pcs_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SCAN_SLOTS = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;
  localparam int TIDX_W     = (SCAN_SLOTS > 1) ? $clog2(SCAN_SLOTS) : 1;

  localparam int MODE_W = 4;
  localparam int SLOT_W = 3;
  localparam int PRIO_W = 8;
  localparam int ST_W   = 3;
  localparam int DL_W   = 64;
  localparam int WAKE_W = 32;

  // operation codes
  localparam logic [MODE_W-1:0] OP_CREATE  = 4'd0;
  localparam logic [MODE_W-1:0] OP_DESTROY = 4'd1;
  localparam logic [MODE_W-1:0] OP_SETST   = 4'd2;
  localparam logic [MODE_W-1:0] OP_SLEEP   = 4'd3;
  localparam logic [MODE_W-1:0] OP_PICK    = 4'd4;
  localparam logic [MODE_W-1:0] OP_NEXT    = 4'd5;
  localparam logic [MODE_W-1:0] OP_ACTIVE  = 4'd6;
  localparam logic [MODE_W-1:0] OP_LOAD    = 4'd7;
  localparam logic [MODE_W-1:0] OP_READ    = 4'd8;

  // slot status codes
  localparam logic [ST_W-1:0] ST_FREE     = 3'd0;
  localparam logic [ST_W-1:0] ST_IDLE     = 3'd1;
  localparam logic [ST_W-1:0] ST_RUNNABLE = 3'd2;
  localparam logic [ST_W-1:0] ST_RUNNING  = 3'd3;
  localparam logic [ST_W-1:0] ST_YIELDED  = 3'd4;
  localparam logic [ST_W-1:0] ST_SLEEPING = 3'd5;

  localparam logic [PRIO_W-1:0] SLOT0_PRIO = 8'd128;
  localparam logic [PRIO_W:0]   PRIO_NONE  = 9'd256;
  localparam logic [WAKE_W-1:0] WAKE_SAT   = 32'hFFFF_FFFE;
  localparam logic [WAKE_W-1:0] WAKE_NEVER = 32'hFFFF_FFFF;

endpackage

>>> design/pcs_if.sv
// valid/ready channel interfaces for the scheduler operation and result items
// depends on pcs_pkg for the field widths
interface pcs_in_if;
  logic                         valid;
  logic                         ready;
  logic [pcs_pkg::MODE_W-1:0]   mode;
  logic [pcs_pkg::SLOT_W-1:0]   slot;
  logic [pcs_pkg::PRIO_W-1:0]   prio;
  logic [pcs_pkg::ST_W-1:0]     new_status;
  logic [pcs_pkg::DL_W-1:0]     time_ms;

  modport source (output valid, mode, slot, prio, new_status, time_ms, input ready);
  modport sink   (input valid, mode, slot, prio, new_status, time_ms, output ready);
endinterface

interface pcs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [pcs_pkg::SLOT_W-1:0]   slot_id;
  logic [pcs_pkg::WAKE_W-1:0]   wake_ms;
  logic [pcs_pkg::ST_W-1:0]     slot_state;
  logic [pcs_pkg::PRIO_W-1:0]   slot_prio;
  logic [pcs_pkg::DL_W-1:0]     slot_deadline;

  modport source (output valid, found, slot_id, wake_ms, slot_state, slot_prio,
                  slot_deadline, input ready);
  modport sink   (input valid, found, slot_id, wake_ms, slot_state, slot_prio,
                  slot_deadline, output ready);
endinterface

>>> design/pcs_sub.sv
// shared 64-bit subtract and compare unit of the scheduler
// depends on pcs_pkg for the deadline width
module pcs_sub (
  input  logic [pcs_pkg::DL_W-1:0] a,
  input  logic [pcs_pkg::DL_W-1:0] b,
  output logic [pcs_pkg::DL_W-1:0] diff,
  output logic                     borrow,
  output logic                     is_zero
);
  import pcs_pkg::*;

  logic [DL_W:0] wide;

  assign wide    = {1'b0, a} - {1'b0, b};
  assign diff    = wide[DL_W-1:0];
  assign borrow  = wide[DL_W];   // a < b
  assign is_zero = (wide[DL_W-1:0] == '0);
endmodule

>>> design/priority_context_scheduler_top.sv
// Priority context scheduler: a table of eight context slots (status,
// priority, 64-bit wake deadline) plus the active slot number. One operation
// item is taken at a time and gives exactly one result item. Create, pick and
// next-wake walk the slots one per cycle through a single 64-bit subtractor
// in S_SCAN, and next-wake then works out its answer in S_FIN; destroy,
// status, sleep, make-active, load and read act on one slot in S_ONE. A result
// waits in an output register, and the next item is accepted once the
// current result is loaded.
// depends on pcs_pkg, pcs_if, pcs_sub and assert_macros.svh
`include "assert_macros.svh"

module priority_context_scheduler_top (
  input  logic clk,
  input  logic rst_n,
  pcs_in_if.sink    in_ch,
  pcs_out_if.source out_ch
);
  import pcs_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ONE, S_FIN, S_DONE} state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SCAN_SLOTS - 1);

  state_t state_r;

  // slot tables
  logic [ST_W-1:0]   status_r   [SCAN_SLOTS];
  logic [PRIO_W-1:0] prio_r     [SCAN_SLOTS];
  logic [DL_W-1:0]   deadline_r [SCAN_SLOTS];
  logic [SLOT_W-1:0] active_r;

  // item being worked on
  logic [MODE_W-1:0] mode_r;
  logic [SLOT_W-1:0] slot_r;
  logic [PRIO_W-1:0] nprio_r;
  logic [ST_W-1:0]   nst_r;
  logic [DL_W-1:0]   time_r;
  logic [SLOT_W-1:0] idx_r;

  // scan bookkeeping
  logic [PRIO_W:0]   best_r;
  logic              any_r;
  logic              busy_r;
  logic [DL_W-1:0]   earliest_r;

  // result being built
  logic              res_found_r;
  logic [SLOT_W-1:0] res_id_r;
  logic [WAKE_W-1:0] res_wake_r;
  logic [ST_W-1:0]   res_st_r;
  logic [PRIO_W-1:0] res_prio_r;
  logic [DL_W-1:0]   res_dl_r;

  // output register
  logic              out_valid_r;
  logic              out_found_r;
  logic [SLOT_W-1:0] out_id_r;
  logic [WAKE_W-1:0] out_wake_r;
  logic [ST_W-1:0]   out_st_r;
  logic [PRIO_W-1:0] out_prio_r;
  logic [DL_W-1:0]   out_dl_r;

  logic [TIDX_W-1:0] cur_idx;
  logic [ST_W-1:0]   cur_st;
  logic [PRIO_W-1:0] cur_prio;
  logic [DL_W-1:0]   cur_dl;
  logic [DL_W-1:0]   sub_a;
  logic [DL_W-1:0]   sub_b;
  logic [DL_W-1:0]   sub_diff;
  logic              sub_borrow;
  logic              sub_zero;
  logic [ST_W-1:0]   pick_st;
  logic              pick_better;
  logic              slot_ok;
  logic              is_last;
  logic              scan_mode;
  logic              in_take;
  logic [WAKE_W-1:0] fin_wake;

  assign cur_idx  = idx_r[TIDX_W-1:0];
  assign cur_st   = status_r[cur_idx];
  assign cur_prio = prio_r[cur_idx];
  assign cur_dl   = deadline_r[cur_idx];
  assign slot_ok  = (int'(slot_r) < NUM_SLOTS);
  assign is_last  = (idx_r == LAST_SLOT);
  assign scan_mode = (in_ch.mode == OP_CREATE) || (in_ch.mode == OP_PICK) ||
                     (in_ch.mode == OP_NEXT);
  assign in_take  = in_ch.valid && in_ch.ready;

  // operand selection for the shared subtractor
  always_comb begin
    sub_a = time_r;
    sub_b = cur_dl;
    if (state_r == S_FIN) begin
      sub_a = earliest_r;
      sub_b = {{(DL_W-WAKE_W){1'b0}}, time_r[WAKE_W-1:0]};
    end else if (mode_r == OP_NEXT) begin
      sub_a = cur_dl;
      sub_b = earliest_r;
    end
  end

  pcs_sub u_sub (
    .a       (sub_a),
    .b       (sub_b),
    .diff    (sub_diff),
    .borrow  (sub_borrow),
    .is_zero (sub_zero)
  );

  // pick: wake expired sleepers and yielded slots, then rank by priority
  always_comb begin
    pick_st = cur_st;
    if ((cur_st == ST_SLEEPING && !sub_borrow) || cur_st == ST_YIELDED) begin
      pick_st = ST_RUNNABLE;
    end
    pick_better = (pick_st == ST_RUNNABLE) && ({1'b0, cur_prio} < best_r);
  end

  // next-wake answer from the earliest deadline
  always_comb begin
    if (busy_r) begin
      fin_wake = '0;
    end else if (!any_r) begin
      fin_wake = WAKE_NEVER;
    end else if (sub_borrow || sub_zero) begin
      fin_wake = '0;
    end else if (sub_diff[DL_W-1:WAKE_W] != '0 || sub_diff[WAKE_W-1:0] == WAKE_NEVER) begin
      fin_wake = WAKE_SAT;
    end else begin
      fin_wake = sub_diff[WAKE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= '0;
      for (int i = 0; i < SCAN_SLOTS; i++) begin
        status_r[i]   <= (i == 0) ? ST_IDLE : ST_FREE;
        prio_r[i]     <= (i == 0) ? SLOT0_PRIO : '0;
        deadline_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            mode_r      <= in_ch.mode;
            slot_r      <= in_ch.slot;
            nprio_r     <= in_ch.prio;
            nst_r       <= in_ch.new_status;
            time_r      <= in_ch.time_ms;
            idx_r       <= scan_mode ? '0 : in_ch.slot;
            best_r      <= PRIO_NONE;
            any_r       <= 1'b0;
            busy_r      <= 1'b0;
            earliest_r  <= '0;
            res_found_r <= 1'b0;
            res_id_r    <= '0;
            res_wake_r  <= '0;
            res_st_r    <= '0;
            res_prio_r  <= '0;
            res_dl_r    <= '0;
            state_r     <= scan_mode ? S_SCAN : S_ONE;
          end
        end
        S_SCAN: begin
          case (mode_r)
            OP_CREATE: begin
              if (cur_st == ST_FREE) begin
                status_r[cur_idx]   <= ST_IDLE;
                prio_r[cur_idx]     <= nprio_r;
                deadline_r[cur_idx] <= '0;
                res_found_r         <= 1'b1;
                res_id_r            <= idx_r;
                state_r             <= S_DONE;
              end else if (is_last) begin
                state_r <= S_DONE;
              end else begin
                idx_r <= idx_r + SLOT_W'(1);
              end
            end
            OP_PICK: begin
              status_r[cur_idx] <= pick_st;
              if (pick_better) begin
                best_r      <= {1'b0, cur_prio};
                res_found_r <= 1'b1;
                res_id_r    <= idx_r;
              end
              if (is_last) begin
                state_r <= S_DONE;
              end else begin
                idx_r <= idx_r + SLOT_W'(1);
              end
            end
            default: begin
              if (cur_st == ST_RUNNABLE || cur_st == ST_RUNNING || cur_st == ST_YIELDED) begin
                busy_r  <= 1'b1;
                state_r <= S_FIN;
              end else begin
                if (cur_st == ST_SLEEPING && (!any_r || sub_borrow)) begin
                  earliest_r <= cur_dl;
                  any_r      <= 1'b1;
                end
                if (is_last) begin
                  state_r <= S_FIN;
                end else begin
                  idx_r <= idx_r + SLOT_W'(1);
                end
              end
            end
          endcase
        end
        S_ONE: begin
          case (mode_r)
            OP_DESTROY: begin
              if (slot_ok && slot_r != active_r) begin
                status_r[cur_idx]   <= ST_FREE;
                prio_r[cur_idx]     <= '0;
                deadline_r[cur_idx] <= '0;
              end
            end
            OP_SETST: begin
              if (slot_ok && nst_r <= ST_SLEEPING) begin
                status_r[cur_idx] <= nst_r;
              end
            end
            OP_SLEEP: begin
              if (slot_ok) begin
                status_r[cur_idx]   <= ST_SLEEPING;
                deadline_r[cur_idx] <= time_r;
              end
            end
            OP_ACTIVE: begin
              if (slot_ok) begin
                active_r <= slot_r;
              end
            end
            OP_LOAD: begin
              if (slot_ok && slot_r == active_r) begin
                status_r[cur_idx] <= ST_RUNNABLE;
              end
            end
            OP_READ: begin
              if (slot_ok) begin
                res_st_r   <= cur_st;
                res_prio_r <= cur_prio;
                res_dl_r   <= cur_dl;
              end
            end
            default: begin
            end
          endcase
          state_r <= S_DONE;
        end
        S_FIN: begin
          res_wake_r <= fin_wake;
          state_r    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_found_r <= res_found_r;
            out_id_r    <= res_id_r;
            out_wake_r  <= res_wake_r;
            out_st_r    <= res_st_r;
            out_prio_r  <= res_prio_r;
            out_dl_r    <= res_dl_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.slot_id       = out_id_r;
  assign out_ch.wake_ms       = out_wake_r;
  assign out_ch.slot_state    = out_st_r;
  assign out_ch.slot_prio     = out_prio_r;
  assign out_ch.slot_deadline = out_dl_r;

  `PCS_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_take, !in_ch.ready, "item accepted while busy")
  `PCS_ASSERT(a_found_mode, clk, rst_n, (state_r == S_DONE && res_found_r) |-> (mode_r == OP_CREATE || mode_r == OP_PICK), "found set outside create or pick")
  `PCS_ASSERT(a_wake_mode, clk, rst_n, (state_r == S_DONE && res_wake_r != '0) |-> (mode_r == OP_NEXT), "wake answer outside next wake")
endmodule
